/* sv/u2d_pkg.sv */
`default_nettype none
package u2d_pkg;

  localparam int unsigned ValueW      = 64;
  localparam int unsigned NumDigits   = 20;
  localparam int unsigned BcdW        = 4 * NumDigits;
  localparam int unsigned NdigW       = $clog2(NumDigits + 1);
  localparam int unsigned IdxW        = $clog2(NumDigits);
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned NumSteps    = ValueW / BitsPerStep;
  localparam int unsigned StepCntW    = $clog2(NumSteps);
  localparam int unsigned CharW       = 6;
  localparam logic [CharW-1:0] CharZero = CharW'(48);
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  // one converted value waiting for the back end
  typedef struct packed {
    logic [BcdW-1:0]  bcd;
    logic [NdigW-1:0] ndig;
  } conv_t;

  typedef enum logic [2:0] {
    FrIdle = 3'b001,
    FrConv = 3'b010,
    FrPush = 3'b100
  } front_state_e;

endpackage
`default_nettype wire

/* sv/u2d_front.sv */
`default_nettype none
module u2d_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic [u2d_pkg::ValueW-1:0]  value_i,
  output logic                             q_push_o,
  input  wire logic                        q_full_i,
  output u2d_pkg::conv_t                   q_data_o
);

  u2d_pkg::front_state_e             state_q, state_d;
  logic [u2d_pkg::StepCntW-1:0]      cnt_q, cnt_d;
  logic [u2d_pkg::ValueW-1:0]        bin_q, bin_d;
  logic [u2d_pkg::BcdW-1:0]          bcd_q, bcd_d;
  logic [u2d_pkg::ValueW-1:0]        bin_v;
  logic [u2d_pkg::BcdW-1:0]          bcd_v;
  logic [u2d_pkg::NdigW-1:0]         ndig;

  // shift-and-add-3, several bits per cycle
  always_comb begin
    bin_v = bin_q;
    bcd_v = bcd_q;
    for (int s = 0; s < int'(u2d_pkg::BitsPerStep); s++) begin
      for (int d = 0; d < int'(u2d_pkg::NumDigits); d++) begin
        if (bcd_v[4*d +: 4] >= 4'd5) begin
          bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + 4'd3;
        end
      end
      bcd_v = {bcd_v[u2d_pkg::BcdW-2:0], bin_v[u2d_pkg::ValueW-1]};
      bin_v = {bin_v[u2d_pkg::ValueW-2:0], 1'b0};
    end
  end

  // number of significant digits, at least one
  always_comb begin
    ndig = u2d_pkg::NdigW'(1);
    for (int d = 1; d < int'(u2d_pkg::NumDigits); d++) begin
      if (bcd_q[4*d +: 4] != 4'd0) begin
        ndig = u2d_pkg::NdigW'(d + 1);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    q_push_o = 1'b0;
    case (state_q)
      u2d_pkg::FrIdle: begin
        if (push_i) begin
          bin_d   = value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = u2d_pkg::FrConv;
        end
      end
      u2d_pkg::FrConv: begin
        bin_d = bin_v;
        bcd_d = bcd_v;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == u2d_pkg::StepCntW'(u2d_pkg::NumSteps - 1)) begin
          state_d = u2d_pkg::FrPush;
        end
      end
      u2d_pkg::FrPush: begin
        q_push_o = 1'b1;
        if (!q_full_i) begin
          state_d = u2d_pkg::FrIdle;
        end
      end
      default: begin
        state_d = u2d_pkg::FrIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= u2d_pkg::FrIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign full_o        = (state_q != u2d_pkg::FrIdle);
  assign q_data_o.bcd  = bcd_q;
  assign q_data_o.ndig = ndig;

endmodule
`default_nettype wire

/* sv/u2d_queue.sv */
`default_nettype none
module u2d_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire u2d_pkg::conv_t  wdata_i,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output u2d_pkg::conv_t       rdata_o
);

  u2d_pkg::conv_t                 mem_q [u2d_pkg::QueueDepth];
  logic [u2d_pkg::QueuePtrW-1:0]  wptr_q, rptr_q;
  logic [u2d_pkg::QueueCntW-1:0]  cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == u2d_pkg::QueueCntW'(u2d_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

/* sv/u2d_back.sv */
`default_nettype none
module u2d_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  output logic                            q_pop_o,
  input  wire u2d_pkg::conv_t             q_data_i,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic [u2d_pkg::CharW-1:0]       digit_char_o,
  output logic                            is_last_o
);

  logic                           cur_valid_q, cur_valid_d;
  logic [u2d_pkg::BcdW-1:0]       bcd_q, bcd_d;
  logic [u2d_pkg::IdxW-1:0]       idx_q, idx_d;
  logic                           out_valid_q, out_valid_d;
  logic [u2d_pkg::CharW-1:0]      char_q, char_d;
  logic                           last_q, last_d;
  logic                           adv;
  logic [3:0]                     digit;

  assign adv     = !out_valid_q || pop_i;
  assign q_pop_o = !cur_valid_q && !q_empty_i;
  assign digit   = bcd_q[{idx_q, 2'b00} +: 4];

  always_comb begin
    cur_valid_d = cur_valid_q;
    bcd_d       = bcd_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      cur_valid_d = 1'b1;
      bcd_d       = q_data_i.bcd;
      idx_d       = u2d_pkg::IdxW'(q_data_i.ndig - 1'b1);
    end else if (cur_valid_q && adv) begin
      // most significant digit first
      out_valid_d = 1'b1;
      char_d      = u2d_pkg::CharZero + u2d_pkg::CharW'(digit);
      last_d      = (idx_q == '0);
      idx_d       = idx_q - 1'b1;
      if (idx_q == '0) begin
        cur_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign empty_o      = !out_valid_q;
  assign digit_char_o = char_q;
  assign is_last_o    = last_q;

endmodule
`default_nettype wire

/* sv/u64_to_decimal_ascii.sv */
// channel   | handshake      | beat carries
// ----------+----------------+------------------------------------------
// input     | push / full    | value_i (64-bit unsigned)
// result    | pop / empty    | digit_char_o (ascii digit), is_last_o
//
// the front converts a value to 20 bcd digits, 4 bits per cycle through the
// shift-add-3 stage, then hands it to a 2-entry queue; it takes no new value
// until the converted one is in the queue. the back loads an entry and then
// emits one digit beat per cycle while the result port is popped. reset
// clears control only; a stalled result port backs up the queue and then the
// front, nothing is dropped.
`default_nettype none
module u64_to_decimal_ascii (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [u2d_pkg::ValueW-1:0] value_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [u2d_pkg::CharW-1:0]       digit_char_o,
  output logic                            is_last_o
);

  logic           fq_push, fq_full, fq_pop, fq_empty;
  u2d_pkg::conv_t fq_wdata, fq_rdata;
  logic           back_pop;

  assign back_pop = pop && !empty;

  u2d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .value_i  (value_i),
    .q_push_o (fq_push),
    .q_full_i (fq_full),
    .q_data_o (fq_wdata)
  );

  u2d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .full_o  (fq_full),
    .wdata_i (fq_wdata),
    .pop_i   (fq_pop),
    .empty_o (fq_empty),
    .rdata_o (fq_rdata)
  );

  u2d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (fq_empty),
    .q_pop_o      (fq_pop),
    .q_data_i     (fq_rdata),
    .empty_o      (empty),
    .pop_i        (back_pop),
    .digit_char_o (digit_char_o),
    .is_last_o    (is_last_o)
  );

endmodule
`default_nettype wire

/* sv/u2d_checker.sv */
`default_nettype none
module u2d_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  input  wire logic                       full,
  input  wire logic [u2d_pkg::ValueW-1:0] value_i,
  input  wire logic                       empty,
  input  wire logic                       pop,
  input  wire logic [u2d_pkg::CharW-1:0]  digit_char_o,
  input  wire logic                       is_last_o
);

  // nothing shows on the result side straight out of reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown right after reset");

  // every result beat is an ascii digit
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (digit_char_o >= 6'd48 && digit_char_o <= 6'd57))
    else $error("result is not a decimal digit");

  // the front holds one value at a time while it converts
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && value_i == value_i) |=> full)
    else $error("input taken while conversion still running");

  // a stalled result beat holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(digit_char_o) && $stable(is_last_o)))
    else $error("stalled result beat changed");

endmodule

bind u64_to_decimal_ascii u2d_checker u_chk (.*);
`default_nettype wire

/* verif/u64_to_decimal_ascii_checker.sv */
module u64_to_decimal_ascii_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic                              full_i,
  input  logic [u2d_pkg::ValueW-1:0]        value_i,
  input  logic                              empty_i,
  input  logic                              pop_i,
  input  logic [u2d_pkg::CharW-1:0]         digit_char_i,
  input  logic                              is_last_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [u2d_pkg::CharW-1:0] ch;
    logic                      last;
  } digit_beat_t;

  digit_beat_t digits_q[$];
  int unsigned mismatches = 0;
  int unsigned waiting_beats = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting_beats;

  // append the decimal string of a value, most significant digit first
  function automatic void expand_decimal(input logic [u2d_pkg::ValueW-1:0] value);
    digit_beat_t rev[$];
    digit_beat_t b;
    logic [u2d_pkg::ValueW-1:0] rest;
    rest = value;
    do begin
      b.ch   = u2d_pkg::CharZero + u2d_pkg::CharW'(rest % 10);
      b.last = (rev.size() == 0);
      rev.push_front(b);
      rest = rest / 10;
    end while (rest != 0);
    foreach (rev[i]) digits_q.push_back(rev[i]);
  endfunction

  always @(posedge clk_i) begin : watch_beats
    digit_beat_t want;
    if (rst_ni) begin
      if (push_i && !full_i) expand_decimal(value_i);
      if (pop_i && !empty_i) begin
        if (digits_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected digit beat char=%0d last=%0b",
                     $realtime, digit_char_i, is_last_i);
        end else begin
          want = digits_q.pop_front();
          if (digit_char_i !== want.ch || is_last_i !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: digit beat mismatch: expected char=%0d last=%0b,",
                        " got char=%0d last=%0b"},
                       $realtime, want.ch, want.last, digit_char_i, is_last_i);
          end
        end
      end
      waiting_beats = digits_q.size();
    end
  end

endmodule

/* verif/u64_to_decimal_ascii_test.sv */
module u64_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk;
  logic                       rst_n;
  logic                       push;
  logic                       full;
  logic [u2d_pkg::ValueW-1:0] value;
  logic                       empty;
  logic                       pop;
  logic [u2d_pkg::CharW-1:0]  digit_char;
  logic                       is_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 77;
  int          hold_left = 0;

  u64_to_decimal_ascii i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .value_i     (value),
    .empty       (empty),
    .pop         (pop),
    .digit_char_o(digit_char),
    .is_last_o   (is_last)
  );

  u64_to_decimal_ascii_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_i      (full),
    .value_i     (value),
    .empty_i     (empty),
    .pop_i       (pop),
    .digit_char_i(digit_char),
    .is_last_i   (is_last),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #2_000_000;
    $display("u64_to_decimal_ascii regression: fail");
    $finish;
  end

  // result side: random pops, or a long hold-off when asked
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [u2d_pkg::ValueW-1:0] pow10(input int unsigned p);
    logic [u2d_pkg::ValueW-1:0] acc;
    acc = 1;
    repeat (p) acc = acc * 10;
    return acc;
  endfunction

  function automatic logic [u2d_pkg::ValueW-1:0] rand_value();
    logic [u2d_pkg::ValueW-1:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return raw;
      1: return raw >> (u2d_pkg::ValueW - $urandom_range(1, u2d_pkg::ValueW));
      2: return pow10($urandom_range(0, 19)) + $urandom_range(0, 2) - 1;
      3: return pow10($urandom_range(1, 19)) - 1;
      4: return $urandom_range(0, 999);
      default: return ~u2d_pkg::ValueW'(0) - $urandom_range(0, 1000);
    endcase
  endfunction

  task automatic send_value(input logic [u2d_pkg::ValueW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    value <= v;
    do @(posedge clk); while (full);
  endtask

  initial begin
    logic [u2d_pkg::ValueW-1:0] corner_values [19];
    corner_values = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
      64'd99999999, 64'd100000000, 64'd4294967295, 64'd4294967296,
      64'd999999999999999999, 64'd1000000000000000000,
      64'd9999999999999999999, 64'd10000000000000000000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'hFFFF_FFFF_FFFF_FFFF
    };
    push  = 1'b0;
    value = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) send_value(corner_values[i]);
    repeat (50) send_value(rand_value());

    send_idle_pct = 77;
    recv_idle_pct = 22;
    repeat (50) send_value(rand_value());

    // no idling; the long result stall backs up the queue and the front
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 300;
    repeat (50) send_value(rand_value());

    push <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("u64_to_decimal_ascii regression: pass");
    end else begin
      $display("u64_to_decimal_ascii regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/u2d_pkg.sv
sv/u2d_front.sv
sv/u2d_queue.sv
sv/u2d_back.sv
sv/u64_to_decimal_ascii.sv
sv/u2d_checker.sv
verif/u64_to_decimal_ascii_checker.sv
verif/u64_to_decimal_ascii_test.sv
